// ===== rtl/pfx_pkg.sv =====
// Package for the postfix expression evaluator.
// Holds the stack size, character codes, status codes and the cell control types.
// It has no dependencies and is used by every module of the block.
package pfx_pkg;

    localparam int STACK_DEPTH = 6;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int DIV_STEPS   = VAL_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_EQUALS  = 8'd61;
    localparam logic [7:0] CH_HASH    = 8'd35;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_VALUE      = 4'd1;
    localparam logic [3:0] ST_NOT_SINGLE = 4'd2;
    localparam logic [3:0] ST_INVALID    = 4'd3;
    localparam logic [3:0] ST_UNDERFLOW  = 4'd4;
    localparam logic [3:0] ST_OVERFLOW   = 4'd5;
    localparam logic [3:0] ST_DIVZERO    = 4'd6;
    localparam logic [3:0] ST_QUIT       = 4'd7;
    localparam logic [3:0] ST_HALTED     = 4'd8;

    typedef logic [1:0] t_cell_op;

    localparam t_cell_op CELL_HOLD = 2'd0;
    localparam t_cell_op CELL_PUSH = 2'd1;
    localparam t_cell_op CELL_POP1 = 2'd2;
    localparam t_cell_op CELL_POP2 = 2'd3;

    typedef struct packed {
        t_cell_op           head_op;
        t_cell_op           tail_op;
        logic [VAL_W-1:0]   head_value;
    } t_stack_ctrl;

endpackage

// ===== rtl/pfx_cell.sv =====
// One stack cell of the postfix expression evaluator.
// Holds a single entry and moves data to and from its neighbours on push and pop.
// Depends on pfx_pkg.
module pfx_cell (
    input  logic                     i_clk,
    input  pfx_pkg::t_cell_op        i_op,
    input  logic [pfx_pkg::VAL_W-1:0] i_upper,
    input  logic [pfx_pkg::VAL_W-1:0] i_lower1,
    input  logic [pfx_pkg::VAL_W-1:0] i_lower2,
    output logic [pfx_pkg::VAL_W-1:0] o_value
);
    import pfx_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    always_comb begin
        case (i_op)
            CELL_PUSH: n_value = i_upper;
            CELL_POP1: n_value = i_lower1;
            CELL_POP2: n_value = i_lower2;
            default:   n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/pfx_div.sv =====
// Iterative signed divider for the postfix expression evaluator.
// Restoring division on magnitudes, one quotient bit per cycle, truncating toward zero.
// Depends on pfx_pkg.
module pfx_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pfx_pkg::VAL_W-1:0] i_dividend,
    input  logic [pfx_pkg::VAL_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [pfx_pkg::VAL_W-1:0] o_quotient
);
    import pfx_pkg::*;

    logic                  r_busy;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [VAL_W-1:0]      r_rem;
    logic [VAL_W-1:0]      r_quo;
    logic [VAL_W-1:0]      r_den;
    logic                  r_neg;
    logic [VAL_W:0]        w_trial;
    logic [VAL_W-1:0]      w_abs_a;
    logic [VAL_W-1:0]      w_abs_b;

    assign w_abs_a = i_dividend[VAL_W-1] ? (~i_dividend + VAL_W'(1)) : i_dividend;
    assign w_abs_b = i_divisor[VAL_W-1]  ? (~i_divisor + VAL_W'(1))  : i_divisor;
    assign w_trial = {r_rem, r_quo[VAL_W-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_abs_a;
            r_den <= w_abs_b;
            r_neg <= i_dividend[VAL_W-1] ^ i_divisor[VAL_W-1];
        end else if (r_busy) begin
            if (!w_trial[VAL_W]) begin
                r_rem <= w_trial[VAL_W-1:0];
                r_quo <= {r_quo[VAL_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[VAL_W-2:0], r_quo[VAL_W-1]};
                r_quo <= {r_quo[VAL_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? (~r_quo + VAL_W'(1)) : r_quo;

endmodule

// ===== rtl/postfix_expression_evaluator_unit.sv =====
// Top level of the postfix expression evaluator.
// Instantiates the row of stack cells and the iterative divider.
// Depends on pfx_pkg, pfx_cell and pfx_div.
//
// The block takes one ASCII character per word on the slave channel and gives
// exactly one result word per character on the master channel. Digits push
// their value, the four operators combine the top two entries, '=' reports the
// single remaining value, and '#', overflow, underflow or division by zero halts the block until reset.
// The stack is a row of cells; the top entry sits in the first cell and every
// push or pop moves each entry one or two cells along, all together.
// A character is taken in the idle state and evaluated in the execute state.
// A division runs through the divider at one quotient bit a cycle.
// The result sits in an output register; the next character is taken while
// it waits, and evaluation holds only while the register is still full or the divider is busy.
// When the receiver stalls, the word on the master channel stays unchanged.
// Synchronous reset empties the stack, clears the halt and drops tvalid.
module postfix_expression_evaluator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status [3:0], result_value [35:4], zero fill
);
    import pfx_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [7:0]        r_char;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_halted, n_halted;
    logic              r_out_valid;
    logic [3:0]        r_out_status;
    logic [VAL_W-1:0]  r_out_value;
    logic              w_load;
    logic [3:0]        w_status;
    logic [VAL_W-1:0]  w_value;
    logic              w_slot_free;
    logic              w_div_start;
    logic              w_div_busy;
    logic [VAL_W-1:0]  w_quotient;
    logic [VAL_W-1:0]  w_alu;
    logic [VAL_W-1:0]  w_prod;
    logic [VAL_W-1:0]  w_top;
    logic [VAL_W-1:0]  w_next;
    logic              w_is_digit;
    logic              w_is_op;
    t_stack_ctrl       w_ctrl;
    logic [VAL_W-1:0]  w_cell [STACK_DEPTH];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_slot_free   = !r_out_valid || m_axis_tready;

    assign w_top      = w_cell[0];
    assign w_next     = w_cell[1];
    assign w_prod     = w_next * w_top;
    assign w_is_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign w_is_op    = (r_char == CH_PLUS) || (r_char == CH_MINUS) ||
                        (r_char == CH_STAR) || (r_char == CH_SLASH);

    always_comb begin
        case (r_char)
            CH_PLUS:  w_alu = w_next + w_top;
            CH_MINUS: w_alu = w_next - w_top;
            default:  w_alu = w_prod;
        endcase
    end

    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        n_halted          = r_halted;
        w_load            = 1'b0;
        w_status          = ST_OK;
        w_value           = '0;
        w_div_start       = 1'b0;
        w_ctrl.head_op    = CELL_HOLD;
        w_ctrl.tail_op    = CELL_HOLD;
        w_ctrl.head_value = w_alu;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_halted && (r_char == CH_SLASH) && (r_count >= CNT_W'(2))
                        && (w_top != '0)) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if (r_halted) begin
                        w_status = ST_HALTED;
                    end else if (w_is_digit) begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            w_status = ST_OVERFLOW;
                            n_halted = 1'b1;
                        end else begin
                            w_ctrl.head_op    = CELL_PUSH;
                            w_ctrl.tail_op    = CELL_PUSH;
                            w_ctrl.head_value = {{(VAL_W-4){1'b0}}, r_char[3:0]};
                            n_count           = r_count + CNT_W'(1);
                        end
                    end else if (w_is_op) begin
                        if (r_count < CNT_W'(2)) begin
                            w_status = ST_UNDERFLOW;
                            n_count  = '0;
                            n_halted = 1'b1;
                        end else if (r_char == CH_SLASH) begin
                            w_status = ST_DIVZERO;
                            n_count  = r_count - CNT_W'(2);
                            n_halted = 1'b1;
                        end else begin
                            w_ctrl.head_op = CELL_PUSH;
                            w_ctrl.tail_op = CELL_POP1;
                            n_count        = r_count - CNT_W'(1);
                        end
                    end else if (r_char == CH_EQUALS) begin
                        if (r_count == CNT_W'(1)) begin
                            w_status = ST_VALUE;
                            w_value  = w_top;
                            n_count  = '0;
                        end else begin
                            w_status = ST_NOT_SINGLE;
                            if (r_count >= CNT_W'(2)) begin
                                w_ctrl.head_op = CELL_POP2;
                                w_ctrl.tail_op = CELL_POP2;
                                n_count        = r_count - CNT_W'(2);
                            end
                        end
                    end else if (r_char == CH_HASH) begin
                        w_status = ST_QUIT;
                        n_halted = 1'b1;
                    end else if ((r_char == CH_SPACE) || (r_char == CH_NEWLINE)) begin
                        w_status = ST_OK;
                    end else begin
                        w_status = ST_INVALID;
                    end
                end
            end
            S_DIV: begin
                if (!w_div_busy && w_slot_free) begin
                    w_load            = 1'b1;
                    n_state           = S_IDLE;
                    w_ctrl.head_op    = CELL_PUSH;
                    w_ctrl.tail_op    = CELL_POP1;
                    w_ctrl.head_value = w_quotient;
                    n_count           = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_halted <= n_halted;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_char <= s_axis_tdata;
        end
        if (w_load) begin
            r_out_status <= w_status;
            r_out_value  <= w_value;
        end
    end

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            logic [VAL_W-1:0] w_upper;
            logic [VAL_W-1:0] w_lower1;
            logic [VAL_W-1:0] w_lower2;
            t_cell_op         w_op;

            if (g == 0) begin : g_head
                assign w_upper = w_ctrl.head_value;
                assign w_op    = w_ctrl.head_op;
            end else begin : g_tail
                assign w_upper = w_cell[g-1];
                assign w_op    = w_ctrl.tail_op;
            end
            if (g + 1 < STACK_DEPTH) begin : g_l1
                assign w_lower1 = w_cell[g+1];
            end else begin : g_l1_end
                assign w_lower1 = w_cell[g];
            end
            if (g + 2 < STACK_DEPTH) begin : g_l2
                assign w_lower2 = w_cell[g+2];
            end else begin : g_l2_end
                assign w_lower2 = w_cell[g];
            end

            pfx_cell u_cell (
                .i_clk    (i_clk),
                .i_op     (w_op),
                .i_upper  (w_upper),
                .i_lower1 (w_lower1),
                .i_lower2 (w_lower2),
                .o_value  (w_cell[g])
            );
        end
    endgenerate

    pfx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_next),
        .i_divisor  (w_top),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_value, r_out_status};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count exceeds the stack depth");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_halted_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_halted) |=> (r_out_status == ST_HALTED))
        else $error("a halted block reported a status other than halted");

    a_value_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_VALUE)) |-> (r_out_value == '0))
        else $error("nonzero result value with a status other than value");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (w_div_busy && (r_state == S_DIV)))
        else $error("divider not running after a divide was started");

endmodule
